// ===== src/psdpc_pkg.sv =====
package psdpc_pkg;

  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int CNT_W  = 17;
  localparam int IDX_W  = 6;
  localparam int KEY_W  = IDX_W + PORT_W;
  localparam int VRD_W  = 2;

  localparam logic [VRD_W-1:0] VRD_LIKELY   = 2'd0;
  localparam logic [VRD_W-1:0] VRD_POSSIBLE = 2'd1;
  localparam logic [VRD_W-1:0] VRD_EMPTY    = 2'd2;

  localparam logic CFG_LIKELY   = 1'b0;
  localparam logic CFG_POSSIBLE = 1'b1;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_src;
    logic scan_pair;
    logic scan_rep;
    logic ins_pair;
    logic ins_src;
    logic cnt_rd;
    logic cnt_wr;
    logic set_ovf;
    logic rep_fin;
  } cmd_t;

  typedef struct packed {
    logic src_hit;
    logic pair_hit;
    logic scan_end;
    logic src_full;
    logic pair_full;
    logic last;
  } sts_t;

endpackage

// ===== src/port_scan_distinct_port_classifier.sv =====
// Processing: a record scans the stored sources and, on a source hit, the stored pairs;
//   each table is read one entry per cycle from a single read port.
// Final record: a report pass over the stored sources follows, up to one result per cycle.
// Throughput: one record at a time; start is taken when busy is low.
// Reset (rst_n, synchronous): tables empty, overflow flag and thresholds zero.
// Results are strobed by out_valid for one cycle; the receiver cannot stall.
module port_scan_distinct_port_classifier #(
  parameter int MAX_SOURCES = 64,
  parameter int MAX_PAIRS   = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [psdpc_pkg::ADDR_W-1:0] in_src_addr,
  input  logic [psdpc_pkg::PORT_W-1:0] in_dest_port,
  input  logic                         in_end_of_log,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [psdpc_pkg::CNT_W-1:0]  cfg_wdata,
  output logic                         out_valid,
  output logic [psdpc_pkg::ADDR_W-1:0] out_report_addr,
  output logic [psdpc_pkg::CNT_W-1:0]  out_port_count,
  output logic [psdpc_pkg::VRD_W-1:0]  out_verdict,
  output logic                         out_overflowed,
  output logic                         out_last_of_report
);

  psdpc_pkg::cmd_t cmd;
  psdpc_pkg::sts_t sts;

  psdpc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  psdpc_datapath #(
    .MAX_SOURCES (MAX_SOURCES),
    .MAX_PAIRS   (MAX_PAIRS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_src_addr        (in_src_addr),
    .in_dest_port       (in_dest_port),
    .in_end_of_log      (in_end_of_log),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_report_addr    (out_report_addr),
    .out_port_count     (out_port_count),
    .out_verdict        (out_verdict),
    .out_overflowed     (out_overflowed),
    .out_last_of_report (out_last_of_report)
  );

endmodule

// ===== src/psdpc_datapath.sv =====
module psdpc_datapath #(
  parameter int MAX_SOURCES = 64,
  parameter int MAX_PAIRS   = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  psdpc_pkg::cmd_t                  cmd,
  output psdpc_pkg::sts_t                  sts,
  input  logic [psdpc_pkg::ADDR_W-1:0]     in_src_addr,
  input  logic [psdpc_pkg::PORT_W-1:0]     in_dest_port,
  input  logic                             in_end_of_log,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [psdpc_pkg::CNT_W-1:0]      cfg_wdata,
  output logic                             out_valid,
  output logic [psdpc_pkg::ADDR_W-1:0]     out_report_addr,
  output logic [psdpc_pkg::CNT_W-1:0]      out_port_count,
  output logic [psdpc_pkg::VRD_W-1:0]      out_verdict,
  output logic                             out_overflowed,
  output logic                             out_last_of_report
);

  localparam int SW  = $clog2(MAX_SOURCES + 1);
  localparam int PW  = $clog2(MAX_PAIRS + 1);
  localparam int CW  = (SW > PW) ? SW : PW;
  localparam int SAW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int PAW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

  logic [psdpc_pkg::ADDR_W-1:0] src_mem [MAX_SOURCES];
  logic [psdpc_pkg::CNT_W-1:0]  cnt_mem [MAX_SOURCES];
  logic [psdpc_pkg::KEY_W-1:0]  pair_mem [MAX_PAIRS];

  logic [psdpc_pkg::ADDR_W-1:0] src_q;
  logic [psdpc_pkg::CNT_W-1:0]  cnt_q;
  logic [psdpc_pkg::KEY_W-1:0]  pair_q;

  logic [psdpc_pkg::ADDR_W-1:0] addr_r;
  logic [psdpc_pkg::PORT_W-1:0] port_r;
  logic                         last_r;
  logic [SAW-1:0]               idx_r;
  logic [CW-1:0]                scan_r;
  logic                         cmp_vld_r;
  logic [SAW-1:0]               cmp_idx_r;
  logic [SW-1:0]                src_used_r;
  logic [PW-1:0]                pair_used_r;
  logic                         ovf_r;
  logic [psdpc_pkg::CNT_W-1:0]  likely_r;
  logic [psdpc_pkg::CNT_W-1:0]  possible_r;

  logic                         pend_vld_r;
  logic [psdpc_pkg::ADDR_W-1:0] pend_addr_r;
  logic [psdpc_pkg::CNT_W-1:0]  pend_cnt_r;
  logic [psdpc_pkg::VRD_W-1:0]  pend_vrd_r;

  logic                         out_valid_r;
  logic [psdpc_pkg::ADDR_W-1:0] out_addr_r;
  logic [psdpc_pkg::CNT_W-1:0]  out_cnt_r;
  logic [psdpc_pkg::VRD_W-1:0]  out_vrd_r;
  logic                         out_ovf_r;
  logic                         out_last_r;

  logic [CW-1:0]                limit;
  logic                         scanning;
  logic                         rd_go;
  logic [SAW-1:0]               key_idx;
  logic [psdpc_pkg::KEY_W-1:0]  key;
  logic                         qual;
  logic [psdpc_pkg::VRD_W-1:0]  qual_vrd;

  assign scanning = cmd.scan_src | cmd.scan_pair | cmd.scan_rep;
  assign limit    = cmd.scan_pair ? CW'(pair_used_r) : CW'(src_used_r);
  assign rd_go    = scanning && (scan_r < limit);
  assign key_idx  = cmd.ins_src ? src_used_r[SAW-1:0] : idx_r;
  assign key      = {psdpc_pkg::IDX_W'(key_idx), port_r};

  always_comb begin
    qual     = 1'b0;
    qual_vrd = psdpc_pkg::VRD_LIKELY;
    if (cnt_q >= likely_r) begin
      qual = 1'b1;
    end else if (cnt_q >= possible_r) begin
      qual     = 1'b1;
      qual_vrd = psdpc_pkg::VRD_POSSIBLE;
    end
  end

  assign sts.src_hit   = cmp_vld_r && (src_q == addr_r);
  assign sts.pair_hit  = cmp_vld_r && (pair_q == key);
  assign sts.scan_end  = !cmp_vld_r && (scan_r >= limit);
  assign sts.src_full  = src_used_r >= SW'(MAX_SOURCES);
  assign sts.pair_full = pair_used_r >= PW'(MAX_PAIRS);
  assign sts.last      = last_r;

  always_ff @(posedge clk) begin
    if ((cmd.scan_src || cmd.scan_rep) && rd_go) begin
      src_q <= src_mem[scan_r[SAW-1:0]];
    end
    if (cmd.scan_rep && rd_go) begin
      cnt_q <= cnt_mem[scan_r[SAW-1:0]];
    end else if (cmd.cnt_rd) begin
      cnt_q <= cnt_mem[idx_r];
    end
    if (cmd.scan_pair && rd_go) begin
      pair_q <= pair_mem[scan_r[PAW-1:0]];
    end
    if (cmd.ins_pair) begin
      pair_mem[pair_used_r[PAW-1:0]] <= key;
    end
    if (cmd.ins_src) begin
      src_mem[src_used_r[SAW-1:0]] <= addr_r;
      cnt_mem[src_used_r[SAW-1:0]] <= psdpc_pkg::CNT_W'(1);
    end else if (cmd.cnt_wr) begin
      cnt_mem[idx_r] <= cnt_q + psdpc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= in_src_addr;
      port_r <= in_dest_port;
      last_r <= in_end_of_log;
    end
    if (cmd.scan_src && sts.src_hit) begin
      idx_r <= cmp_idx_r;
    end else if (cmd.ins_src) begin
      idx_r <= src_used_r[SAW-1:0];
    end
    if (rd_go) begin
      cmp_idx_r <= scan_r[SAW-1:0];
    end
    if (cmd.scan_rep && cmp_vld_r && qual) begin
      pend_addr_r <= src_q;
      pend_cnt_r  <= cnt_q;
      pend_vrd_r  <= qual_vrd;
    end
    out_ovf_r  <= ovf_r;
    out_last_r <= cmd.rep_fin;
    if (cmd.rep_fin && !pend_vld_r) begin
      out_addr_r <= '0;
      out_cnt_r  <= '0;
      out_vrd_r  <= psdpc_pkg::VRD_EMPTY;
    end else begin
      out_addr_r <= pend_addr_r;
      out_cnt_r  <= pend_cnt_r;
      out_vrd_r  <= pend_vrd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= '0;
      cmp_vld_r   <= 1'b0;
      src_used_r  <= '0;
      pair_used_r <= '0;
      ovf_r       <= 1'b0;
      likely_r    <= '0;
      possible_r  <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.rep_fin | (cmd.scan_rep & cmp_vld_r & qual & pend_vld_r);
      if (cfg_we) begin
        if (cfg_index == psdpc_pkg::CFG_LIKELY) begin
          likely_r <= cfg_wdata;
        end else begin
          possible_r <= cfg_wdata;
        end
      end
      if (cmd.scan_clr) begin
        scan_r    <= '0;
        cmp_vld_r <= 1'b0;
      end else if (scanning) begin
        cmp_vld_r <= rd_go;
        if (rd_go) begin
          scan_r <= scan_r + CW'(1);
        end
      end
      if (cmd.ins_pair) begin
        pair_used_r <= pair_used_r + PW'(1);
      end
      if (cmd.ins_src) begin
        src_used_r <= src_used_r + SW'(1);
      end
      if (cmd.set_ovf) begin
        ovf_r <= 1'b1;
      end
      if (cmd.scan_rep && cmp_vld_r && qual) begin
        pend_vld_r <= 1'b1;
      end
      if (cmd.rep_fin) begin
        pend_vld_r  <= 1'b0;
        src_used_r  <= '0;
        pair_used_r <= '0;
        ovf_r       <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_report_addr    = out_addr_r;
  assign out_port_count     = out_cnt_r;
  assign out_verdict        = out_vrd_r;
  assign out_overflowed     = out_ovf_r;
  assign out_last_of_report = out_last_r;

endmodule

// ===== src/psdpc_ctrl.sv =====
module psdpc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  psdpc_pkg::sts_t sts,
  output psdpc_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SRC, S_PAIR, S_INS, S_INS_NEW, S_CRD, S_CWR, S_DONE, S_REP, S_REP_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SRC;
        end
      end
      S_SRC: begin
        cmd.scan_src = 1'b1;
        if (sts.src_hit) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_PAIR;
        end else if (sts.scan_end) begin
          if (sts.src_full || sts.pair_full) begin
            cmd.set_ovf = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_INS_NEW;
          end
        end
      end
      S_PAIR: begin
        if (sts.pair_hit) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scan_pair = 1'b1;
          if (sts.scan_end) begin
            if (sts.pair_full) begin
              cmd.set_ovf = 1'b1;
              state_nxt   = S_DONE;
            end else begin
              state_nxt = S_INS;
            end
          end
        end
      end
      S_INS: begin
        cmd.ins_pair = 1'b1;
        state_nxt    = S_CRD;
      end
      S_INS_NEW: begin
        cmd.ins_pair = 1'b1;
        cmd.ins_src  = 1'b1;
        state_nxt    = S_DONE;
      end
      S_CRD: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = S_CWR;
      end
      S_CWR: begin
        cmd.cnt_wr = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        cmd.scan_clr = 1'b1;
        state_nxt    = sts.last ? S_REP : S_IDLE;
      end
      S_REP: begin
        cmd.scan_rep = 1'b1;
        if (sts.scan_end) begin
          state_nxt = S_REP_FIN;
        end
      end
      S_REP_FIN: begin
        cmd.rep_fin = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy    <= (state_nxt != S_IDLE);
    end
  end

endmodule

// ===== src/psdpc_checker.sv =====
module psdpc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [psdpc_pkg::ADDR_W-1:0] out_report_addr,
  input logic [psdpc_pkg::CNT_W-1:0]  out_port_count,
  input logic [psdpc_pkg::VRD_W-1:0]  out_verdict,
  input logic                         out_last_of_report
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after item");

  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a pending item");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == psdpc_pkg::VRD_EMPTY |->
      out_report_addr == '0 && out_port_count == '0 && out_last_of_report)
    else $error("bad empty marker");

  a_verdict_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_verdict == psdpc_pkg::VRD_LIKELY ||
      out_verdict == psdpc_pkg::VRD_POSSIBLE || out_verdict == psdpc_pkg::VRD_EMPTY)
    else $error("illegal verdict");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_report |=> !out_valid)
    else $error("result after end of report");

endmodule

bind port_scan_distinct_port_classifier psdpc_checker u_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_report_addr    (out_report_addr),
  .out_port_count     (out_port_count),
  .out_verdict        (out_verdict),
  .out_last_of_report (out_last_of_report)
);
